[design/rau_pkg.sv]
// ----------------------------------------------------------------------------
// rau_pkg
// Shared types and constants of the rational arithmetic unit.
// ----------------------------------------------------------------------------
package rau_pkg;

  localparam int NumW = 34;
  localparam int DenW = 33;
  localparam int CmpW = 2;

  typedef enum logic [3:0] {
    OP_REDUCE = 4'd0,
    OP_ADD    = 4'd1,
    OP_SUB    = 4'd2,
    OP_MUL    = 4'd3,
    OP_DIV    = 4'd4,
    OP_CMP    = 4'd5,
    OP_MAX    = 4'd6,
    OP_NEG    = 4'd7,
    OP_RECIP  = 4'd8
  } op_e;

  localparam logic [CmpW-1:0] CMP_LT = 2'd0;
  localparam logic [CmpW-1:0] CMP_EQ = 2'd1;
  localparam logic [CmpW-1:0] CMP_GT = 2'd2;

  typedef enum logic [3:0] {
    S_IDLE,
    S_MUL,
    S_COMB,
    S_GCD_GO,
    S_GCD_WAIT,
    S_DIVN_GO,
    S_DIVN_WAIT,
    S_DIVD_GO,
    S_DIVD_WAIT,
    S_OUT
  } state_e;

  typedef enum logic [1:0] {
    G_IDLE,
    G_RUN,
    G_FIX
  } gcd_phase_e;

  // Start strobes from the sequencer to the shared units.
  typedef struct packed {
    logic gcd_start;
    logic div_start;
  } unit_ctrl_t;

endpackage

[design/rau_if.sv]
// ----------------------------------------------------------------------------
// rau_req_if / rau_res_if
// Valid/ready channels for request items and result items.
// ----------------------------------------------------------------------------
interface rau_req_if #(
  parameter int OperandWidth = 16
);
  logic                           valid;
  logic                           ready;
  logic [3:0]                     req_type;
  logic signed [OperandWidth-1:0] a_num;
  logic signed [OperandWidth-1:0] a_den;
  logic signed [OperandWidth-1:0] b_num;
  logic signed [OperandWidth-1:0] b_den;

  modport source (output valid, req_type, a_num, a_den, b_num, b_den, input ready);
  modport sink   (input valid, req_type, a_num, a_den, b_num, b_den, output ready);
endinterface

interface rau_res_if import rau_pkg::*; ;
  logic                   valid;
  logic                   ready;
  logic signed [NumW-1:0] res_num;
  logic [DenW-1:0]        res_den;
  logic [CmpW-1:0]        cmp_result;
  logic                   error;

  modport source (output valid, res_num, res_den, cmp_result, error, input ready);
  modport sink   (input valid, res_num, res_den, cmp_result, error, output ready);
endinterface

[design/rau_gcd.sv]
// ----------------------------------------------------------------------------
// rau_gcd
// Binary gcd: one shift or one subtract per cycle, then restores the
// common power of two one bit per cycle.
// ----------------------------------------------------------------------------
module rau_gcd import rau_pkg::*; #(
  parameter int Width = 32
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [Width-1:0] x_i,
  input  logic [Width-1:0] y_i,
  output logic             done_o,
  output logic [Width-1:0] g_o
);
  localparam int KW = $clog2(Width);

  gcd_phase_e       phase_q, phase_d;
  logic [Width-1:0] u_q, u_d, v_q, v_d;
  logic [KW-1:0]    k_q, k_d;

  always_comb begin
    phase_d = phase_q;
    u_d     = u_q;
    v_d     = v_q;
    k_d     = k_q;
    unique case (phase_q)
      G_IDLE: begin
        if (start_i) begin
          u_d     = x_i;
          v_d     = y_i;
          k_d     = '0;
          phase_d = G_RUN;
        end
      end
      G_RUN: begin
        if (u_q == '0) begin
          phase_d = G_FIX;
        end else if (!u_q[0] && !v_q[0]) begin
          u_d = u_q >> 1;
          v_d = v_q >> 1;
          k_d = k_q + KW'(1);
        end else if (!u_q[0]) begin
          u_d = u_q >> 1;
        end else if (!v_q[0]) begin
          v_d = v_q >> 1;
        end else if (u_q >= v_q) begin
          u_d = u_q - v_q;
        end else begin
          v_d = v_q - u_q;
        end
      end
      G_FIX: begin
        if (k_q == '0) begin
          phase_d = G_IDLE;
        end else begin
          v_d = v_q << 1;
          k_d = k_q - KW'(1);
        end
      end
      default: phase_d = G_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= G_IDLE;
    end else begin
      phase_q <= phase_d;
    end
  end

  always_ff @(posedge clk_i) begin
    u_q <= u_d;
    v_q <= v_d;
    k_q <= k_d;
  end

  assign done_o = (phase_q == G_FIX) && (k_q == '0);
  assign g_o    = v_q;

endmodule

[design/rau_div.sv]
// ----------------------------------------------------------------------------
// rau_div
// Restoring unsigned divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module rau_div #(
  parameter int Width = 32
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [Width-1:0] dividend_i,
  input  logic [Width-1:0] divisor_i,
  output logic             done_o,
  output logic [Width-1:0] quotient_o
);
  localparam int CW = $clog2(Width);

  logic             busy_q, done_q;
  logic [CW-1:0]    cnt_q;
  logic [Width:0]   rem_q, rem_sh;
  logic [Width-1:0] quo_q, dvs_q;
  logic             fits;

  assign rem_sh = {rem_q[Width-1:0], quo_q[Width-1]};
  assign fits   = rem_sh >= {1'b0, dvs_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + CW'(1);
        if (cnt_q == CW'(Width - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= '0;
      quo_q <= dividend_i;
      dvs_q <= divisor_i;
    end else if (busy_q) begin
      rem_q <= fits ? (rem_sh - {1'b0, dvs_q}) : rem_sh;
      quo_q <= {quo_q[Width-2:0], fits};
    end
  end

  assign done_o     = done_q;
  assign quotient_o = quo_q;

endmodule

[design/rational_arithmetic_unit_core.sv]
// ----------------------------------------------------------------------------
// rational_arithmetic_unit_core
// Rational arithmetic on two signed fractions with gcd reduction.
// ----------------------------------------------------------------------------
// A request item on req_i carries an opcode and two fractions a and b. The
// block answers every request with one result item on res_o: a reduced
// fraction with the sign on the numerator, a compare code, and an error flag.
// The block works on one item at a time; req_i.ready is high only while idle.
// Sequence: three multiplies and one combine step for the binary
// operations, then a binary gcd over 2*OPERAND_WIDTH bit values with a
// restore of the common factors of two, then two restoring divisions,
// of the numerator and of the denominator by the gcd. The gcd loop and
// the shared divider take most of the time of an item. Errors and
// compares skip the gcd and divider.
// The result stays in its output register with res_o.valid high until the
// receiver takes it; no new request is taken before then.
// Reset returns the sequencer to idle with no result pending.
// ----------------------------------------------------------------------------
module rational_arithmetic_unit_core import rau_pkg::*; #(
  parameter int OPERAND_WIDTH = 16
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  rau_req_if.sink   req_i,
  rau_res_if.source res_o
);
  localparam int W  = OPERAND_WIDTH;
  localparam int PW = 2 * W;
  localparam int EW = (PW > NumW) ? PW : NumW;

  state_e     state_q, state_d;
  unit_ctrl_t ctrl;
  logic [1:0] cnt_q;

  op_e        op_q, acc_op;
  logic [W-1:0] an_q, ad_q, bn_q, bd_q;
  logic       a_neg_q, b_neg_q;
  logic [PW-1:0] prod_q [3];
  logic [PW-1:0] x_q, y_q, g_q, qn_q;
  logic       neg_q;

  logic signed [NumW-1:0] res_num_q;
  logic [DenW-1:0]        res_den_q;
  logic [CmpW-1:0]        cmp_q;
  logic                   err_q;

  // Sign and magnitude of the incoming operands.
  logic         an_s, ad_s, bn_s, bd_s;
  logic [W-1:0] an_m, ad_m, bn_m, bd_m;
  logic         a_neg_in, b_neg_in, acc_err, acc_binary, acc_direct, accept;

  assign an_s = req_i.a_num[W-1];
  assign ad_s = req_i.a_den[W-1];
  assign bn_s = req_i.b_num[W-1];
  assign bd_s = req_i.b_den[W-1];
  assign an_m = an_s ? (W'(0) - W'(req_i.a_num)) : W'(req_i.a_num);
  assign ad_m = ad_s ? (W'(0) - W'(req_i.a_den)) : W'(req_i.a_den);
  assign bn_m = bn_s ? (W'(0) - W'(req_i.b_num)) : W'(req_i.b_num);
  assign bd_m = bd_s ? (W'(0) - W'(req_i.b_den)) : W'(req_i.b_den);
  assign acc_op = op_e'(req_i.req_type);

  always_comb begin
    a_neg_in = (an_s != ad_s) && (an_m != '0);
    b_neg_in = (bn_s != bd_s) && (bn_m != '0);
    if (acc_op == OP_SUB) begin
      b_neg_in = !b_neg_in && (bn_m != '0);
    end
    acc_binary = (acc_op == OP_ADD) || (acc_op == OP_SUB) || (acc_op == OP_MUL) ||
                 (acc_op == OP_DIV) || (acc_op == OP_CMP) || (acc_op == OP_MAX);
    acc_direct = (acc_op == OP_REDUCE) || (acc_op == OP_NEG) || (acc_op == OP_RECIP);
    acc_err    = (req_i.req_type > OP_RECIP) || (ad_m == '0) ||
                 (acc_binary && (bd_m == '0)) ||
                 ((acc_op == OP_DIV) && (bn_m == '0)) ||
                 ((acc_op == OP_RECIP) && (an_m == '0));
  end

  assign accept = req_i.valid && req_i.ready;

  // Shared multiplier operand selection.
  logic [W-1:0]  mul_a, mul_b;
  logic [PW-1:0] mul_p;

  always_comb begin
    unique case (cnt_q)
      2'd0: begin
        mul_a = an_q;
        mul_b = (op_q == OP_MUL) ? bn_q : bd_q;
      end
      2'd1: begin
        mul_a = bn_q;
        mul_b = ad_q;
      end
      default: begin
        mul_a = ad_q;
        mul_b = (op_q == OP_DIV) ? bn_q : bd_q;
      end
    endcase
  end

  assign mul_p = PW'(mul_a) * PW'(mul_b);

  // Combine step: signed add of cross products and sign-magnitude compare.
  logic          xn, yn;
  logic [PW-1:0] sum_mag;
  logic          sum_neg;
  logic [CmpW-1:0] cmp_c;

  always_comb begin
    if (a_neg_q == b_neg_q) begin
      sum_mag = prod_q[0] + prod_q[1];
      sum_neg = a_neg_q;
    end else if (prod_q[0] >= prod_q[1]) begin
      sum_mag = prod_q[0] - prod_q[1];
      sum_neg = a_neg_q;
    end else begin
      sum_mag = prod_q[1] - prod_q[0];
      sum_neg = b_neg_q;
    end
    xn = a_neg_q && (prod_q[0] != '0);
    yn = b_neg_q && (prod_q[1] != '0);
    if (xn != yn) begin
      cmp_c = xn ? CMP_LT : CMP_GT;
    end else if (prod_q[0] == prod_q[1]) begin
      cmp_c = CMP_EQ;
    end else if (xn) begin
      cmp_c = (prod_q[0] > prod_q[1]) ? CMP_LT : CMP_GT;
    end else begin
      cmp_c = (prod_q[0] > prod_q[1]) ? CMP_GT : CMP_LT;
    end
  end

  // Shared gcd and divider.
  logic          gcd_done, div_done;
  logic [PW-1:0] gcd_g, div_quo, div_dividend;

  assign div_dividend = (state_q == S_DIVN_GO) ? x_q : y_q;

  rau_gcd #(.Width(PW)) u_gcd (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (ctrl.gcd_start),
    .x_i     (x_q),
    .y_i     (y_q),
    .done_o  (gcd_done),
    .g_o     (gcd_g)
  );

  rau_div #(.Width(PW)) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (ctrl.div_start),
    .dividend_i (div_dividend),
    .divisor_i  (g_q),
    .done_o     (div_done),
    .quotient_o (div_quo)
  );

  // Final result formatting.
  logic            fin_neg, fin_zero;
  logic [PW-1:0]   fin_den;
  logic [EW-1:0]   num_ext, num_sgn, den_ext;

  always_comb begin
    fin_zero = (qn_q == '0);
    fin_neg  = ((op_q == OP_NEG) ? !neg_q : neg_q) && !fin_zero;
    fin_den  = fin_zero ? PW'(1) : div_quo;
    num_ext  = EW'(qn_q);
    num_sgn  = fin_neg ? (EW'(0) - num_ext) : num_ext;
    den_ext  = EW'(fin_den);
  end

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (req_i.valid) begin
          if (acc_err) begin
            state_d = S_OUT;
          end else if (acc_direct) begin
            state_d = S_GCD_GO;
          end else begin
            state_d = S_MUL;
          end
        end
      end
      S_MUL:       if (cnt_q == 2'd2) state_d = S_COMB;
      S_COMB:      state_d = (op_q == OP_CMP) ? S_OUT : S_GCD_GO;
      S_GCD_GO:    state_d = S_GCD_WAIT;
      S_GCD_WAIT:  if (gcd_done) state_d = S_DIVN_GO;
      S_DIVN_GO:   state_d = S_DIVN_WAIT;
      S_DIVN_WAIT: if (div_done) state_d = S_DIVD_GO;
      S_DIVD_GO:   state_d = S_DIVD_WAIT;
      S_DIVD_WAIT: if (div_done) state_d = S_OUT;
      S_OUT:       if (res_o.ready) state_d = S_IDLE;
      default:     state_d = S_IDLE;
    endcase
  end

  // Outputs of the sequencer.
  always_comb begin
    ctrl.gcd_start = (state_q == S_GCD_GO);
    ctrl.div_start = (state_q == S_DIVN_GO) || (state_q == S_DIVD_GO);
    req_i.ready    = (state_q == S_IDLE);
    res_o.valid    = (state_q == S_OUT);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      if (accept) begin
        cnt_q <= '0;
      end else if (state_q == S_MUL) begin
        cnt_q <= cnt_q + 2'd1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          op_q      <= acc_op;
          an_q      <= an_m;
          ad_q      <= ad_m;
          bn_q      <= bn_m;
          bd_q      <= bd_m;
          a_neg_q   <= a_neg_in;
          b_neg_q   <= b_neg_in;
          neg_q     <= a_neg_in;
          x_q       <= (acc_op == OP_RECIP) ? PW'(ad_m) : PW'(an_m);
          y_q       <= (acc_op == OP_RECIP) ? PW'(an_m) : PW'(ad_m);
          res_num_q <= '0;
          res_den_q <= '0;
          cmp_q     <= CMP_LT;
          err_q     <= acc_err;
        end
      end
      S_MUL: prod_q[cnt_q] <= mul_p;
      S_COMB: begin
        priority if (op_q == OP_CMP) begin
          cmp_q <= cmp_c;
        end else if (op_q == OP_MAX) begin
          x_q   <= (cmp_c != CMP_LT) ? PW'(an_q) : PW'(bn_q);
          y_q   <= (cmp_c != CMP_LT) ? PW'(ad_q) : PW'(bd_q);
          neg_q <= (cmp_c != CMP_LT) ? a_neg_q : b_neg_q;
        end else if ((op_q == OP_MUL) || (op_q == OP_DIV)) begin
          x_q   <= prod_q[0];
          y_q   <= prod_q[2];
          neg_q <= a_neg_q != b_neg_q;
        end else begin
          x_q   <= sum_mag;
          y_q   <= prod_q[2];
          neg_q <= sum_neg;
        end
      end
      S_GCD_WAIT:  if (gcd_done) g_q <= gcd_g;
      S_DIVN_WAIT: if (div_done) qn_q <= div_quo;
      S_DIVD_WAIT: begin
        if (div_done) begin
          res_num_q <= num_sgn[NumW-1:0];
          res_den_q <= den_ext[DenW-1:0];
        end
      end
      default: begin
      end
    endcase
  end

  assign res_o.res_num    = res_num_q;
  assign res_o.res_den    = res_den_q;
  assign res_o.cmp_result = cmp_q;
  assign res_o.error      = err_q;

endmodule
